// ----- rtl/core/ring_trace_buffer_cursor_read_core_defines.svh -----
// ---------------------------------------------------------------------------
// Ring trace buffer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RING_TRACE_BUFFER_CURSOR_READ_CORE_DEFINES_SVH
`define RING_TRACE_BUFFER_CURSOR_READ_CORE_DEFINES_SVH

// same-cycle implication
`define RTBC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtbc assertion failed");

// next-cycle implication
`define RTBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtbc assertion failed");

`endif

// ----- rtl/core/rtbc_pkg.sv -----
// ---------------------------------------------------------------------------
// Ring trace buffer package
// Field widths, command codes and shared control types.
// ---------------------------------------------------------------------------
package rtbc_pkg;

  localparam int BYTE_W   = 8;
  localparam int CURSOR_W = 32;
  localparam int LIMIT_W  = 7;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } rtbc_mod_sts_t;

endpackage

// ----- rtl/core/rtbc_stream_if.sv -----
// ---------------------------------------------------------------------------
// Ring trace buffer stream interfaces
// Valid/ready channels for command words and result words.
// ---------------------------------------------------------------------------
interface rtbc_in_if import rtbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [BYTE_W-1:0]   data_byte;
  logic [CURSOR_W-1:0] read_cursor;
  logic [LIMIT_W-1:0]  read_limit;

  modport source (output valid, cmd, data_byte, read_cursor, read_limit, input ready);
  modport sink   (input valid, cmd, data_byte, read_cursor, read_limit, output ready);
endinterface

interface rtbc_out_if import rtbc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                is_last;
  logic [LIMIT_W-1:0]  byte_count;
  logic [CURSOR_W-1:0] next_cursor;
  logic                fell_behind;

  modport source (output valid, out_byte, is_last, byte_count, next_cursor, fell_behind,
                  input ready);
  modport sink   (input valid, out_byte, is_last, byte_count, next_cursor, fell_behind,
                  output ready);
endinterface

// ----- rtl/core/rtbc_mod_unit.sv -----
// ---------------------------------------------------------------------------
// Ring position lookup
// Ring position of a cursor, found from the written total's ring position
// and the distance back from the total, with one compare and subtract.
// ---------------------------------------------------------------------------
module rtbc_mod_unit import rtbc_pkg::*; #(
  parameter int unsigned RING_BYTES = 4096,
  localparam int unsigned AW = $clog2(RING_BYTES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  logic [AW-1:0]       base_i,
  input  logic [AW:0]         dist_i,
  output rtbc_mod_sts_t       sts_o,
  output logic [AW-1:0]       rem_o
);

  localparam logic [AW:0] CAP = (AW+1)'(RING_BYTES);

  logic          done_r;
  logic [AW-1:0] rem_r;
  logic [AW-1:0] rem_nxt;
  logic [AW:0]   base_x;

  // dist_i never exceeds the ring size, so one wrap fixes the difference
  assign base_x = {1'b0, base_i};

  always_comb begin
    if (base_x >= dist_i) begin
      rem_nxt = AW'(base_x - dist_i);
    end else begin
      rem_nxt = AW'(base_x + CAP - dist_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start_i;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= rem_nxt;
    end
  end

  assign sts_o = '{busy: 1'b0, done: done_r};
  assign rem_o = rem_r;

endmodule

// ----- rtl/core/rtbc_ring_mem.sv -----
// ---------------------------------------------------------------------------
// Ring byte store
// One write port and one registered read port; read data holds when idle.
// ---------------------------------------------------------------------------
module rtbc_ring_mem import rtbc_pkg::*; #(
  parameter int unsigned RING_BYTES = 4096,
  localparam int unsigned AW = $clog2(RING_BYTES)
) (
  input  logic              clk,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_r [RING_BYTES];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (re_i) begin
      rdata_r <= mem_r[raddr_i];
    end
  end

  assign rdata_o = rdata_r;

endmodule

// ----- rtl/core/ring_trace_buffer_cursor_read_core.sv -----
// Appends: one word per cycle while no read is in progress, no result, ring written the cycle of acceptance.
// Reads: the first result word follows the clamp, count, ring position and
//   memory read steps in that order, for any RING_BYTES.
// Then one result per cycle while the receiver is ready, set by the single memory read port.
// Next word accepted the cycle after the last byte read is issued.
// Reset clears head, total count and control; ring contents are not cleared.
// ---------------------------------------------------------------------------
// Ring trace buffer with cursor read
// Byte ring with a 32-bit written total; reads clamp a cursor to the oldest
// held byte and stream up to a limit of bytes from the ring memory.
// ---------------------------------------------------------------------------
`include "ring_trace_buffer_cursor_read_core_defines.svh"

module ring_trace_buffer_cursor_read_core import rtbc_pkg::*; #(
  parameter int unsigned RING_BYTES = 4096,
  parameter int unsigned MAX_READ   = 64
) (
  input logic       clk,
  input logic       rst_n,
  rtbc_in_if.sink   in_ch,
  rtbc_out_if.source out_ch
);

  localparam int unsigned AW = $clog2(RING_BYTES);
  localparam logic [CURSOR_W-1:0] CAP  = CURSOR_W'(RING_BYTES);
  localparam logic [LIMIT_W-1:0]  MAXR = LIMIT_W'(MAX_READ);
  localparam logic [AW-1:0]       LAST_POS = AW'(RING_BYTES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLAMP = 3'd1;
  localparam logic [2:0] S_COUNT = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       head_r;
  logic [AW-1:0]       tmod_r;
  logic [CURSOR_W-1:0] total_r;
  logic [CURSOR_W-1:0] cur_r;
  logic [LIMIT_W-1:0]  lim_r;
  logic                behind_r;
  logic                empty_r;
  logic [LIMIT_W-1:0]  n_r;
  logic [CURSOR_W-1:0] nc_r;
  logic [LIMIT_W-1:0]  rem_r;
  logic [AW-1:0]       pos_r;
  logic [CURSOR_W-1:0] run_r;

  logic                d_v_r;
  logic                dlast_r;
  logic                dzero_r;
  logic [LIMIT_W-1:0]  dcnt_r;
  logic [CURSOR_W-1:0] dnc_r;
  logic                dbehind_r;

  logic                in_acc, wr_acc, rd_acc;
  logic [CURSOR_W-1:0] oldest;
  logic [CURSOR_W-1:0] avail;
  logic [LIMIT_W-1:0]  lim_sat;
  logic                slot_free, issue, load_empty;
  logic                empty_now;
  logic [LIMIT_W-1:0]  n_now;
  logic                mod_start;
  logic [AW:0]         mod_dist;
  rtbc_mod_sts_t       mod_sts;
  logic [AW-1:0]       mod_rem;
  logic [BYTE_W-1:0]   rdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_acc      = in_acc && (in_ch.cmd == CMD_APPEND);
  assign rd_acc      = in_acc && (in_ch.cmd == CMD_READ);

  assign lim_sat = (in_ch.read_limit > MAXR) ? MAXR : in_ch.read_limit;
  assign oldest  = (total_r > CAP) ? (total_r - CAP) : '0;
  assign avail   = total_r - cur_r;

  assign empty_now = (cur_r >= total_r) || (lim_r == '0);
  assign n_now     = empty_now ? '0 :
                     (avail > CURSOR_W'(lim_r)) ? lim_r : avail[LIMIT_W-1:0];

  // a non-empty read lies at most one ring back from the total
  assign mod_dist   = empty_now ? '0 : avail[AW:0];

  assign slot_free  = !d_v_r || out_ch.ready;
  assign issue      = (state_r == S_EMIT) && !empty_r && slot_free;
  assign load_empty = (state_r == S_EMIT) && empty_r && slot_free;
  assign mod_start  = (state_r == S_COUNT);

  rtbc_mod_unit #(.RING_BYTES(RING_BYTES)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mod_start),
    .base_i  (tmod_r),
    .dist_i  (mod_dist),
    .sts_o   (mod_sts),
    .rem_o   (mod_rem)
  );

  rtbc_ring_mem #(.RING_BYTES(RING_BYTES)) u_mem (
    .clk     (clk),
    .we_i    (wr_acc),
    .waddr_i (head_r),
    .wdata_i (in_ch.data_byte),
    .re_i    (issue),
    .raddr_i (pos_r),
    .rdata_o (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (rd_acc) state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_COUNT;
      S_COUNT: state_nxt = S_MOD;
      S_MOD:   if (mod_sts.done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (load_empty || (issue && rem_r == LIMIT_W'(1))) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tmod_r  <= '0;
      total_r <= '0;
      d_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_acc) begin
        head_r  <= (head_r == LAST_POS) ? '0 : head_r + 1'b1;
        // total modulo ring size, restarting when the total wraps
        tmod_r  <= (total_r == '1 || tmod_r == LAST_POS) ? '0 : tmod_r + 1'b1;
        total_r <= total_r + 1'b1;
      end
      if (issue || load_empty) begin
        d_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        d_v_r <= 1'b0;
      end
    end
  end

  // read setup and position walk
  always_ff @(posedge clk) begin
    if (rd_acc) begin
      cur_r <= in_ch.read_cursor;
      lim_r <= lim_sat;
    end
    if (state_r == S_CLAMP) begin
      if (cur_r < oldest) begin
        cur_r    <= oldest;
        behind_r <= 1'b1;
      end else begin
        behind_r <= 1'b0;
      end
    end
    if (state_r == S_COUNT) begin
      empty_r <= empty_now;
      n_r     <= n_now;
    end
    if (state_r == S_MOD) begin
      nc_r  <= cur_r + CURSOR_W'(n_r);
      rem_r <= n_r;
      run_r <= cur_r;
      pos_r <= mod_rem;
    end
    if (issue) begin
      rem_r <= rem_r - 1'b1;
      run_r <= run_r + 1'b1;
      if (run_r == '1) begin
        pos_r <= '0;
      end else begin
        pos_r <= (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
      end
    end
  end

  // result metadata beside the memory read register
  always_ff @(posedge clk) begin
    if (issue) begin
      dlast_r   <= (rem_r == LIMIT_W'(1));
      dzero_r   <= 1'b0;
      dcnt_r    <= (rem_r == LIMIT_W'(1)) ? n_r : '0;
      dnc_r     <= (rem_r == LIMIT_W'(1)) ? nc_r : '0;
      dbehind_r <= behind_r;
    end else if (load_empty) begin
      dlast_r   <= 1'b1;
      dzero_r   <= 1'b1;
      dcnt_r    <= '0;
      dnc_r     <= cur_r;
      dbehind_r <= behind_r;
    end
  end

  assign out_ch.valid       = d_v_r;
  assign out_ch.out_byte    = dzero_r ? '0 : rdata;
  assign out_ch.is_last     = dlast_r;
  assign out_ch.byte_count  = dcnt_r;
  assign out_ch.next_cursor = dnc_r;
  assign out_ch.fell_behind = dbehind_r;

  `RTBC_ASSERT_IMPL(a_rem_range, (state_r == S_EMIT) && !empty_r,
                    (rem_r != '0) && (rem_r <= n_r))
  `RTBC_ASSERT_IMPL(a_pos_range, state_r == S_EMIT, pos_r <= LAST_POS)
  `RTBC_ASSERT_IMPL(a_mod_done_state, mod_sts.done, state_r == S_MOD)
  `RTBC_ASSERT_IMPL(a_empty_word, d_v_r && dzero_r, dlast_r && (dcnt_r == '0))
  `RTBC_ASSERT_NEXT(a_empty_load, load_empty, d_v_r && dzero_r)

endmodule

// ----- dv/tb_ring_trace_buffer_cursor_read_core.sv -----
// ---------------------------------------------------------------------------
// Ring trace buffer cursor read testbench
// Drives append and read words into the core and predicts every result word
// from a private copy of the ring, head and written total. Directed words
// cover empty, caught-up, zero and saturated limits and far-off cursors;
// random words follow, with a long receiver hold-off and idle bursts on
// both channels.
// ---------------------------------------------------------------------------
typedef struct packed {
  logic                          cmd;
  logic [rtbc_pkg::BYTE_W-1:0]   data_byte;
  logic [rtbc_pkg::CURSOR_W-1:0] read_cursor;
  logic [rtbc_pkg::LIMIT_W-1:0]  read_limit;
} trace_word_t;

typedef struct packed {
  logic [rtbc_pkg::BYTE_W-1:0]   out_byte;
  logic                          is_last;
  logic [rtbc_pkg::LIMIT_W-1:0]  byte_count;
  logic [rtbc_pkg::CURSOR_W-1:0] next_cursor;
  logic                          fell_behind;
} read_beat_t;

class trace_scoreboard #(int unsigned DEPTH = 4096, int unsigned MAX_RD = 64);
  logic [7:0]  ring_mem [DEPTH];
  int unsigned head = 0;
  logic [31:0] total_written = 32'd0;
  read_beat_t  pending_q [$];
  int unsigned errors = 0;

  function logic [31:0] oldest_held();
    return (total_written > DEPTH) ? total_written - DEPTH : 32'd0;
  endfunction

  function int unsigned outstanding();
    return pending_q.size();
  endfunction

  // accepted input word: update ring state or queue the read's result words
  function void note_word(trace_word_t w);
    logic [31:0] cur;
    logic [31:0] lim;
    logic [31:0] n;
    logic        behind;
    read_beat_t  beat;
    if (w.cmd == rtbc_pkg::CMD_APPEND) begin
      ring_mem[head] = w.data_byte;
      head = (head + 1) % DEPTH;
      total_written = total_written + 32'd1;
    end else begin
      cur = w.read_cursor;
      behind = 1'b0;
      if (cur < oldest_held()) begin
        cur = oldest_held();
        behind = 1'b1;
      end
      lim = (w.read_limit > MAX_RD) ? MAX_RD : w.read_limit;
      if (cur >= total_written || lim == 0) begin
        beat = '{out_byte: '0, is_last: 1'b1, byte_count: '0, next_cursor: cur,
                 fell_behind: behind};
        pending_q.push_back(beat);
      end else begin
        n = total_written - cur;
        if (n > lim) n = lim;
        for (int unsigned i = 0; i < n; i++) begin
          beat.out_byte    = ring_mem[(cur + i) % DEPTH];
          beat.is_last     = (i + 1 == n);
          beat.byte_count  = beat.is_last ? n[6:0] : '0;
          beat.next_cursor = beat.is_last ? cur + n : '0;
          beat.fell_behind = behind;
          pending_q.push_back(beat);
        end
      end
    end
  endfunction

  function void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, want, got);
    end
  endfunction

  function void check_beat(read_beat_t got);
    read_beat_t want;
    if (pending_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word: expected none, actual byte 0x%0h last %0b",
               $time, got.out_byte, got.is_last);
      $display("%0t:   count %0d cursor 0x%0h behind %0b", $time, got.byte_count,
               got.next_cursor, got.fell_behind);
    end else begin
      want = pending_q.pop_front();
      cmp_field("out_byte", want.out_byte, got.out_byte);
      cmp_field("is_last", want.is_last, got.is_last);
      cmp_field("byte_count", want.byte_count, got.byte_count);
      cmp_field("next_cursor", want.next_cursor, got.next_cursor);
      cmp_field("fell_behind", want.fell_behind, got.fell_behind);
    end
  endfunction
endclass

module tb_ring_trace_buffer_cursor_read_core import rtbc_pkg::*;;

  localparam int unsigned RING_DEPTH  = 4096;
  localparam int unsigned READ_MAX    = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 300;

  logic clk;
  logic rst_n;

  rtbc_in_if  in_if ();
  rtbc_out_if out_if ();

  ring_trace_buffer_cursor_read_core #(
    .RING_BYTES(RING_DEPTH),
    .MAX_READ  (READ_MAX)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  trace_scoreboard #(RING_DEPTH, READ_MAX) sb;

  bit          tx_idle_en  = 1'b1;
  bit          rx_stall_en = 1'b1;
  bit          hold_req    = 1'b0;
  int unsigned cycles      = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** ring_trace_buffer_cursor_read_core: FAILED **");
    $finish;
  end

  // result side
  initial begin
    read_beat_t  got;
    int unsigned rx_hold;
    rx_hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = '{out_byte: out_if.out_byte, is_last: out_if.is_last,
                byte_count: out_if.byte_count, next_cursor: out_if.next_cursor,
                fell_behind: out_if.fell_behind};
        sb.check_beat(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
        rx_hold = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic idle_tx(input int unsigned n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic push_word(input trace_word_t w);
    if (tx_idle_en && $urandom_range(0, 4) == 0) idle_tx($urandom_range(1, 4));
    in_if.valid       <= 1'b1;
    in_if.cmd         <= w.cmd;
    in_if.data_byte   <= w.data_byte;
    in_if.read_cursor <= w.read_cursor;
    in_if.read_limit  <= w.read_limit;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic put_byte(input logic [7:0] d);
    trace_word_t w;
    w.cmd         = CMD_APPEND;
    w.data_byte   = d;
    w.read_cursor = $urandom;
    w.read_limit  = 7'($urandom_range(0, 127));
    push_word(w);
  endtask

  task automatic fetch(input logic [31:0] cur, input logic [6:0] lim);
    trace_word_t w;
    w.cmd         = CMD_READ;
    w.data_byte   = 8'($urandom_range(0, 255));
    w.read_cursor = cur;
    w.read_limit  = lim;
    push_word(w);
  endtask

  task automatic drain_wait();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // appends and tail reads near the head; some clamped, some far off, some noise
  task automatic random_item();
    int unsigned sel;
    logic [31:0] tot;
    logic [31:0] old;
    logic [31:0] cur;
    sel = $urandom_range(0, 99);
    tot = sb.total_written;
    old = sb.oldest_held();
    if (sel < 45) begin
      put_byte(8'($urandom_range(0, 255)));
    end else if (sel < 80) begin
      cur = tot - $urandom_range(0, 96);
      if (cur < old || cur > tot) cur = old;
      fetch(cur, 7'($urandom_range(1, READ_MAX)));
    end else if (sel < 90) begin
      cur = (old > 0) ? $urandom_range(0, old - 1) : $urandom;
      fetch(cur, 7'($urandom_range(1, READ_MAX)));
    end else begin
      fetch($urandom, 7'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    logic [31:0] old;
    logic [31:0] tot;
    sb = new();
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.cmd         <= CMD_APPEND;
    in_if.data_byte   <= '0;
    in_if.read_cursor <= '0;
    in_if.read_limit  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty ring, then a few bytes
    fetch(32'd0, 7'd1);
    fetch(32'hFFFF_FFFF, 7'd127);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'hA5);
    put_byte(8'h5A);
    put_byte(8'h01);
    put_byte(8'h80);
    put_byte(8'h7F);
    put_byte(8'hFE);
    fetch(32'd0, 7'd0);
    fetch(32'd0, 7'd127);
    fetch(32'd0, 7'd1);
    fetch(32'd3, 7'd64);
    fetch(32'd8, 7'd64);
    fetch(32'd7, 7'd2);
    fetch(32'h8000_0000, 7'd64);

    for (int k = 0; k < 160; k++) begin
      if (k % 40 == 0) begin
        tx_idle_en  = ($urandom_range(0, 3) != 0);
        rx_stall_en = ($urandom_range(0, 3) != 0);
      end
      random_item();
    end

    drain_wait();

    old = sb.oldest_held();
    tot = sb.total_written;
    fetch(32'd0, 7'd64);
    fetch(old - 1, 7'd5);
    fetch(old, 7'd64);
    fetch(((old / RING_DEPTH) + 1) * RING_DEPTH - 10, 7'd20);
    fetch(tot - 1, 7'd64);
    fetch(tot, 7'd1);
    fetch(32'd0, 7'd0);
    fetch(32'hFFFF_FFFF, 7'd127);
    fetch(tot - 64, 7'd64);

    // long hold-off on the result side while words keep coming
    hold_req = 1'b1;
    for (int k = 0; k < 300; k++) begin
      if (k < 200 && k % 40 == 0) begin
        tx_idle_en  = ($urandom_range(0, 3) != 0);
        rx_stall_en = ($urandom_range(0, 3) != 0);
      end else if (k == 200) begin
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
      end
      random_item();
    end

    drain_wait();
    repeat (40) @(posedge clk);

    if (sb.outstanding() != 0) begin
      $display("%0t: %0d result words never arrived", $time, sb.outstanding());
    end
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** ring_trace_buffer_cursor_read_core: PASSED **");
    end else begin
      $display("** ring_trace_buffer_cursor_read_core: FAILED **");
    end
    $finish;
  end

endmodule
